### hw/rtl/alt_pkg.sv
// Shared types and codes for the array linked list table.
package alt_pkg;

    localparam int OP_W     = 2;
    localparam int KEY_IN_W = 16;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 3;
    localparam int HEAD_W   = 4;

    localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture op and key, restart scan
        logic scan;      // issue next slot read, compare previous
        logic take_hit;  // latch matching slot
        logic ins_a;     // write new slot key/links, set valid
        logic ins_b;     // back-link old head, move head
        logic del_rd;    // read links of the victim slot
        logic del_wr;    // relink neighbors, clear valid
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic hit;
        logic miss;
        logic op_insert;
        logic op_delete;
    } t_sts;

endpackage

### hw/rtl/array_linked_list_table.sv
// Top level: doubly linked list kept in a table of slots.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-----------------------------------
//  item in   | start high, busy low      | i_op, i_key
//  result    | o_valid, one cycle        | o_status, o_slot, o_head_slot
//
// One item at a time. Slots are scanned one per cycle through the key memory
// read port, and the scan stops at the first hit or after the last slot.
// Insert then writes the new slot and back-links the old head; delete reads
// the victim's links, then relinks its neighbors. Op code three skips the scan.
// busy drops the cycle after the strobe. Reset is synchronous and clears
// the valid bits and the head; the receiver cannot stall.
module array_linked_list_table
    import alt_pkg::*;
#(
    parameter int SLOTS     = 8,
    parameter int KEY_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     i_op,
    input  logic [KEY_IN_W-1:0] i_key,
    output logic                o_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_slot,
    output logic [HEAD_W-1:0]   o_head_slot
);

    t_cmd w_cmd;
    t_sts w_sts;

    alt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_op),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_done  (o_valid)
    );

    alt_dpath #(
        .SLOTS     (SLOTS),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (i_op),
        .i_key       (i_key),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_status    (o_status),
        .o_slot      (o_slot),
        .o_head_slot (o_head_slot)
    );

    a_hit_miss_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_sts.hit && w_sts.miss))
        else $error("scan reports hit and miss together");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_slot == '0))
        else $error("slot nonzero on a failed item");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy)
        else $error("controller not idle after result");

endmodule

### hw/rtl/alt_dpath.sv
// Datapath: slot memories, valid bits, scan pipeline and list head.
module alt_dpath
    import alt_pkg::*;
#(
    parameter int SLOTS     = 8,
    parameter int KEY_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [OP_W-1:0]     i_op,
    input  logic [KEY_IN_W-1:0] i_key,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_slot,
    output logic [HEAD_W-1:0]   o_head_slot
);

    localparam int IW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);
    localparam logic [LW-1:0] NONE = LW'(SLOTS);

    logic [KEY_WIDTH-1:0] m_key  [SLOTS];
    logic [LW-1:0]        m_next [SLOTS];
    logic [LW-1:0]        m_prev [SLOTS];

    logic [OP_W-1:0]      r_op;
    logic [KEY_WIDTH-1:0] r_key;
    logic [LW-1:0]        r_head;
    logic [SLOTS-1:0]     r_valid;
    logic [LW-1:0]        r_idx;
    logic [IW-1:0]        r_cmp_idx;
    logic                 r_cmp_live;
    logic [KEY_WIDTH-1:0] r_key_rd;
    logic [IW-1:0]        r_pos;
    logic                 r_found;
    logic [LW-1:0]        r_prev_rd;
    logic [LW-1:0]        r_next_rd;

    logic w_hit;
    logic w_miss;
    logic w_issue;

    assign w_issue = i_cmd.scan && (r_idx != NONE);

    always_comb begin
        w_hit = 1'b0;
        if (r_cmp_live) begin
            if (r_op == OP_INSERT) begin
                w_hit = !r_valid[r_cmp_idx];
            end else begin
                w_hit = r_valid[r_cmp_idx] && (r_key_rd == r_key);
            end
        end
    end

    // all reads issued and the last compare done
    assign w_miss = (r_idx == NONE) && !r_cmp_live;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= NONE;
            r_valid    <= '0;
            r_idx      <= '0;
            r_cmp_live <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx      <= '0;
                r_cmp_live <= 1'b0;
                r_found    <= 1'b0;
            end else if (i_cmd.scan) begin
                r_cmp_live <= w_issue;
                if (w_issue) begin
                    r_idx <= r_idx + LW'(1);
                end
            end
            if (i_cmd.take_hit) begin
                r_found <= 1'b1;
            end
            if (i_cmd.ins_a) begin
                r_valid[r_pos] <= 1'b1;
            end
            if (i_cmd.ins_b) begin
                r_head <= LW'(r_pos);
            end
            if (i_cmd.del_wr) begin
                r_valid[r_pos] <= 1'b0;
                if (r_prev_rd == NONE) begin
                    r_head <= r_next_rd;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_key <= KEY_WIDTH'(i_key);
        end
        if (i_cmd.take_hit) begin
            r_pos <= r_cmp_idx;
        end
    end

    // key store
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_a) begin
            m_key[r_pos] <= r_key;
        end
        if (w_issue) begin
            r_key_rd  <= m_key[r_idx[IW-1:0]];
            r_cmp_idx <= r_idx[IW-1:0];
        end
    end

    // next links
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_a) begin
            m_next[r_pos] <= r_head;
        end else if (i_cmd.del_wr && (r_prev_rd != NONE)) begin
            m_next[r_prev_rd[IW-1:0]] <= r_next_rd;
        end
        if (i_cmd.del_rd) begin
            r_next_rd <= (m_next[r_pos] < NONE) ? m_next[r_pos] : NONE;
        end
    end

    // prev links
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_a) begin
            m_prev[r_pos] <= NONE;
        end else if (i_cmd.ins_b && (r_head != NONE)) begin
            m_prev[r_head[IW-1:0]] <= LW'(r_pos);
        end else if (i_cmd.del_wr && (r_next_rd != NONE)) begin
            m_prev[r_next_rd[IW-1:0]] <= r_prev_rd;
        end
        if (i_cmd.del_rd) begin
            r_prev_rd <= (m_prev[r_pos] < NONE) ? m_prev[r_pos] : NONE;
        end
    end

    always_comb begin
        if (r_found) begin
            o_status = ST_OK;
        end else if (r_op == OP_INSERT) begin
            o_status = ST_OVERFLOW;
        end else begin
            o_status = ST_MISSING;
        end
    end

    assign o_slot      = r_found ? SLOT_W'(r_pos) : '0;
    assign o_head_slot = HEAD_W'(r_head);

    assign o_sts.hit       = w_hit;
    assign o_sts.miss      = w_miss;
    assign o_sts.op_insert = (r_op == OP_INSERT);
    assign o_sts.op_delete = (r_op == OP_DELETE);

endmodule

### hw/rtl/alt_ctrl.sv
// Controller: sequences scan, insert and delete writeback, and the result strobe.
module alt_ctrl
    import alt_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [OP_W-1:0] i_op,
    input  t_sts            i_sts,
    output t_cmd            o_cmd,
    output logic            o_busy,
    output logic            o_done
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_INS_A  = 7'b0000100,
        S_INS_B  = 7'b0001000,
        S_DEL_RD = 7'b0010000,
        S_DEL_WR = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_op == OP_NONE) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit) begin
                    o_cmd.take_hit = 1'b1;
                    if (i_sts.op_insert) begin
                        n_state = S_INS_A;
                    end else if (i_sts.op_delete) begin
                        n_state = S_DEL_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (i_sts.miss) begin
                    n_state = S_DONE;
                end
            end
            S_INS_A: begin
                o_cmd.ins_a = 1'b1;
                n_state     = S_INS_B;
            end
            S_INS_B: begin
                o_cmd.ins_b = 1'b1;
                n_state     = S_DONE;
            end
            S_DEL_RD: begin
                o_cmd.del_rd = 1'b1;
                n_state      = S_DEL_WR;
            end
            S_DEL_WR: begin
                o_cmd.del_wr = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

### test/tb_top.sv
// Self-checking testbench for the array linked list table.
`timescale 1ns / 100ps

import alt_pkg::*;

localparam int NUM_SLOTS = 8;
localparam logic [HEAD_W-1:0] NO_LINK = HEAD_W'(NUM_SLOTS);

typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [HEAD_W-1:0]   head;
} t_list_result;

// Shadow copy of the slot table; predicts one result per accepted item.
class list_scoreboard;
    logic [KEY_IN_W-1:0] slot_key[NUM_SLOTS];
    bit                  slot_valid[NUM_SLOTS];
    logic [HEAD_W-1:0]   next_link[NUM_SLOTS];
    logic [HEAD_W-1:0]   prev_link[NUM_SLOTS];
    logic [HEAD_W-1:0]   list_head;
    t_list_result        expected_q[$];
    int mismatches;
    int checked;
    int hits;
    int misses;
    int overflows;
    int op_count[4];

    function new();
        foreach (slot_valid[i]) slot_valid[i] = 1'b0;
        list_head = NO_LINK;
    endfunction

    function int lowest_match(logic [KEY_IN_W-1:0] key);
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_valid[i] && slot_key[i] == key) return i;
        end
        return NUM_SLOTS;
    endfunction

    function int lowest_free();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!slot_valid[i]) return i;
        end
        return NUM_SLOTS;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void note_item(logic [OP_W-1:0] op, logic [KEY_IN_W-1:0] key);
        t_list_result      res;
        int                pos;
        logic [HEAD_W-1:0] p;
        logic [HEAD_W-1:0] n;
        res.status = ST_MISSING;
        res.slot   = '0;
        op_count[op]++;
        case (op)
            OP_SEARCH: begin
                pos = lowest_match(key);
                if (pos < NUM_SLOTS) begin
                    res.status = ST_OK;
                    res.slot   = SLOT_W'(pos);
                end
            end
            OP_INSERT: begin
                pos = lowest_free();
                if (pos < NUM_SLOTS) begin
                    slot_key[pos]   = key;
                    slot_valid[pos] = 1'b1;
                    next_link[pos]  = list_head;
                    prev_link[pos]  = NO_LINK;
                    if (list_head < NO_LINK) prev_link[list_head] = HEAD_W'(pos);
                    list_head  = HEAD_W'(pos);
                    res.status = ST_OK;
                    res.slot   = SLOT_W'(pos);
                end else begin
                    res.status = ST_OVERFLOW;
                end
            end
            OP_DELETE: begin
                pos = lowest_match(key);
                if (pos < NUM_SLOTS) begin
                    p = prev_link[pos];
                    n = next_link[pos];
                    if (p < NO_LINK) next_link[p] = n;
                    else list_head = n;
                    if (n < NO_LINK) prev_link[n] = p;
                    slot_valid[pos] = 1'b0;
                    res.status = ST_OK;
                    res.slot   = SLOT_W'(pos);
                end
            end
            default: ;  // unused code: no state change
        endcase
        res.head = list_head;
        if (res.status == ST_OK && op != OP_INSERT) hits++;
        if (res.status == ST_MISSING) misses++;
        if (res.status == ST_OVERFLOW) overflows++;
        expected_q.push_back(res);
    endfunction

    task report(string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    task check_result(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] slot,
                      logic [HEAD_W-1:0] head);
        t_list_result exp;
        if (expected_q.size() == 0) begin
            report($sformatf("unexpected result status=%0d slot=%0d head=%0d",
                             status, slot, head));
        end else begin
            exp = expected_q.pop_front();
            checked++;
            if (status !== exp.status)
                report($sformatf("result %0d status %0d, want %0d",
                                 checked, status, exp.status));
            if (slot !== exp.slot)
                report($sformatf("result %0d slot %0d, want %0d", checked, slot, exp.slot));
            if (head !== exp.head)
                report($sformatf("result %0d head %0d, want %0d", checked, head, exp.head));
        end
    endtask

    task flush_leftovers();
        while (expected_q.size() != 0) begin
            void'(expected_q.pop_front());
            report("expected result never arrived");
        end
    endtask
endclass

module tb_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_GAP     = 8;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    logic                busy;
    logic [OP_W-1:0]     i_op    = OP_SEARCH;
    logic [KEY_IN_W-1:0] i_key   = '0;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [SLOT_W-1:0]   o_slot;
    logic [HEAD_W-1:0]   o_head_slot;

    list_scoreboard sb = new();
    int cycles = 0;
    logic [KEY_IN_W-1:0] key_pool[6];

    array_linked_list_table #(
        .SLOTS     (NUM_SLOTS),
        .KEY_WIDTH (KEY_IN_W)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_key       (i_key),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_slot      (o_slot),
        .o_head_slot (o_head_slot)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Values read here are the ones from before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) sb.check_result(o_status, o_slot, o_head_slot);
            if (start && !busy) sb.note_item(i_op, i_key);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    task send_item(logic [OP_W-1:0] op, logic [KEY_IN_W-1:0] key, int idle_pct);
        int gap;
        gap = 0;
        // idle only once the block is ready, so the gap shows at its input
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while (busy);
            gap = 1;
            while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
                @(posedge i_clk);
                gap++;
            end
        end
        start <= 1'b1;
        i_op  <= op;
        i_key <= key;
        do @(posedge i_clk); while (busy);
    endtask

    // Fill-heavy stretches push the table into overflow, drain-heavy ones empty it.
    function logic [OP_W-1:0] pick_op(bit filling);
        int unsigned r;
        r = $urandom_range(99);
        if (filling) begin
            if (r < 55) return OP_INSERT;
            if (r < 75) return OP_SEARCH;
            if (r < 97) return OP_DELETE;
        end else begin
            if (r < 20) return OP_INSERT;
            if (r < 50) return OP_SEARCH;
            if (r < 95) return OP_DELETE;
        end
        return OP_NONE;
    endfunction

    task random_phase(int count, int idle_pct);
        logic [KEY_IN_W-1:0] key;
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0) foreach (key_pool[j]) key_pool[j] = KEY_IN_W'($urandom);
            if ($urandom_range(99) < 15) key = KEY_IN_W'($urandom);
            else key = key_pool[$urandom_range(5)];
            send_item(pick_op((i / 30) % 2 == 0), key, idle_pct);
        end
    endtask

    initial begin
        logic [KEY_IN_W-1:0] drain_keys[6];
        drain_keys = '{16'hFFFF, 16'hA5A5, 16'h5A5A, 16'h0001, 16'h8000, 16'h3C3C};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, unused code, duplicates, overflow, unlink at
        // head / tail / middle, absent key, slot reuse, drain to empty.
        send_item(OP_SEARCH, 16'h1234, 0);
        send_item(OP_DELETE, 16'h1234, 0);
        send_item(OP_NONE,   16'hFFFF, 0);
        send_item(OP_INSERT, 16'h0000, 0);
        send_item(OP_INSERT, 16'hFFFF, 0);
        send_item(OP_INSERT, 16'hA5A5, 0);
        send_item(OP_INSERT, 16'hA5A5, 0);
        send_item(OP_SEARCH, 16'hA5A5, 0);
        send_item(OP_INSERT, 16'h5A5A, 0);
        send_item(OP_INSERT, 16'h0001, 0);
        send_item(OP_INSERT, 16'h8000, 0);
        send_item(OP_INSERT, 16'h7FFF, 0);
        send_item(OP_INSERT, 16'h1111, 0);
        send_item(OP_SEARCH, 16'hFFFF, 0);
        send_item(OP_DELETE, 16'h7FFF, 0);
        send_item(OP_DELETE, 16'h0000, 0);
        send_item(OP_DELETE, 16'hA5A5, 0);
        send_item(OP_SEARCH, 16'hA5A5, 0);
        send_item(OP_DELETE, 16'h9999, 0);
        send_item(OP_NONE,   16'h0000, 0);
        send_item(OP_INSERT, 16'h3C3C, 0);
        foreach (drain_keys[i]) send_item(OP_DELETE, drain_keys[i], 0);

        random_phase(185, 19);
        random_phase(185, 45);
        random_phase(185, 0);
        start <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        sb.flush_leftovers();

        $display("Checked %0d results: %0d searches, %0d inserts, %0d deletes, %0d unused codes",
                 sb.checked, sb.op_count[OP_SEARCH], sb.op_count[OP_INSERT],
                 sb.op_count[OP_DELETE], sb.op_count[OP_NONE]);
        $display("Key hits %0d, misses %0d, overflows %0d",
                 sb.hits, sb.misses, sb.overflows);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
